// File: sv/page_run_free_list_allocator_defines.svh
// Assertion macros shared by the page run allocator RTL.
`ifndef PAGE_RUN_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define PAGE_RUN_FREE_LIST_ALLOCATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PRFL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PRFL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/prfl_pkg.sv
// Shared types, codes and defaults of the page run allocator.
`default_nettype none

package prfl_pkg;

    // Default geometry
    localparam int PAGE_ENTRIES_DEF = 1024;
    localparam int PAGE_SHIFT_DEF   = 12;

    // Fixed field widths
    localparam int KIND_W      = 1;
    localparam int COUNT_W     = 11;
    localparam int ADDR_W      = 32;
    localparam int STATUS_W    = 2;
    localparam int RUN_INDEX_W = 10;
    localparam int FREE_RUNS_W = 11;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_ALLOC = 1'b0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_IGNORED   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [COUNT_W-1:0] page_count;
        logic [ADDR_W-1:0]  address;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [ADDR_W-1:0]      run_address;
        logic [RUN_INDEX_W-1:0] run_index;
        logic                   reused;
        logic [FREE_RUNS_W-1:0] free_runs;
    } rsp_t;

    // Table port controls from the sequencer
    typedef struct packed {
        logic rd_en;
        logic link_we;
        logic len_we;
    } mem_ctl_t;

endpackage

`default_nettype wire

// File: sv/prfl_store.sv
// Link and run length tables, one write port and one registered read port.
`default_nettype none

module prfl_store #(
    parameter int PAGE_ENTRIES = prfl_pkg::PAGE_ENTRIES_DEF,
    localparam int AW = $clog2(PAGE_ENTRIES),
    localparam int LW = AW + 1
) (
    input  wire logic                       clk,
    input  wire prfl_pkg::mem_ctl_t         mem_ctl,
    input  wire logic [AW-1:0]              rd_addr,
    input  wire logic [AW-1:0]              wr_addr,
    input  wire logic [LW-1:0]              link_wdata,
    input  wire logic [prfl_pkg::COUNT_W-1:0] len_wdata,
    output logic [LW-1:0]                   rd_link,
    output logic [prfl_pkg::COUNT_W-1:0]    rd_len
);
    import prfl_pkg::*;

    logic [LW-1:0]      link_mem [PAGE_ENTRIES];
    logic [COUNT_W-1:0] len_mem  [PAGE_ENTRIES];
    logic [LW-1:0]      rd_link_reg;
    logic [COUNT_W-1:0] rd_len_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (mem_ctl.link_we)
        begin
            link_mem[wr_addr] <= link_wdata;
        end
        if (mem_ctl.len_we)
        begin
            len_mem[wr_addr] <= len_wdata;
        end
    end

    // Read port, registered
    always_ff @(posedge clk)
    begin
        if (mem_ctl.rd_en)
        begin
            rd_link_reg <= link_mem[rd_addr];
            rd_len_reg  <= len_mem[rd_addr];
        end
    end

    assign rd_link = rd_link_reg;
    assign rd_len  = rd_len_reg;

endmodule

`default_nettype wire

// File: sv/prfl_ctrl.sv
// Sequencer: list walk, unlink, bump allocation, free append and result register.
`default_nettype none

module prfl_ctrl #(
    parameter int PAGE_ENTRIES = prfl_pkg::PAGE_ENTRIES_DEF,
    parameter int PAGE_SHIFT   = prfl_pkg::PAGE_SHIFT_DEF,
    localparam int AW = $clog2(PAGE_ENTRIES),
    localparam int LW = AW + 1
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire prfl_pkg::req_t               req,
    input  wire logic [prfl_pkg::ADDR_W-1:0]  heap_base,
    output logic                              done,
    output prfl_pkg::rsp_t                    rsp,
    output prfl_pkg::mem_ctl_t                mem_ctl,
    output logic [AW-1:0]                     rd_addr,
    output logic [AW-1:0]                     wr_addr,
    output logic [LW-1:0]                     link_wdata,
    output logic [prfl_pkg::COUNT_W-1:0]      len_wdata,
    input  wire logic [LW-1:0]                rd_link,
    input  wire logic [prfl_pkg::COUNT_W-1:0] rd_len
);
    import prfl_pkg::*;

    localparam int PW = ADDR_W - PAGE_SHIFT;
    localparam int SW = ((LW > COUNT_W) ? LW : COUNT_W) + 1;
    localparam int RW = ((PW > LW) ? PW : LW) + 1;
    localparam logic [LW-1:0] NIL      = LW'(PAGE_ENTRIES);
    localparam logic [LW-1:0] STEP_MAX = LW'(PAGE_ENTRIES - 1);

    localparam logic [2:0] S_IDLE       = 3'd0;
    localparam logic [2:0] S_DISPATCH   = 3'd1;
    localparam logic [2:0] S_WALK       = 3'd2;
    localparam logic [2:0] S_BUMP       = 3'd3;
    localparam logic [2:0] S_FREE_RANGE = 3'd4;
    localparam logic [2:0] S_FREE_PAGE  = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic [KIND_W-1:0]  kind_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [LW-1:0]      head_reg, head_next;
    logic [LW-1:0]      tail_reg, tail_next;
    logic [LW-1:0]      free_cnt_reg, free_cnt_next;
    logic [LW-1:0]      bump_reg, bump_next;
    logic [LW-1:0]      prev_reg, prev_next;
    logic [LW-1:0]      cur_reg, cur_next;
    logic [LW-1:0]      steps_reg, steps_next;
    logic [PW-1:0]      page_reg, page_next;
    logic               done_reg, done_next;
    rsp_t               rsp_reg, rsp_next;

    // Finish bus for the result register
    logic                fin;
    logic [STATUS_W-1:0] fin_status;
    logic [AW-1:0]       fin_idx;
    logic                fin_ok;
    logic                fin_reused;

    // Helpers
    logic [SW-1:0] bump_sum;
    logic [RW-1:0] page_ext;
    logic [RW-1:0] page_end;
    logic [LW-1:0] unlink_head;
    logic          list_empty;

    assign busy       = (state_reg != S_IDLE);
    assign bump_sum   = SW'(bump_reg) + SW'(count_reg);
    assign page_ext   = RW'(page_reg);
    assign page_end   = page_ext + RW'(count_reg);
    assign unlink_head = (prev_reg == NIL) ? rd_link : head_reg;
    assign list_empty = (head_reg >= NIL) || (tail_reg >= NIL);

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        free_cnt_next = free_cnt_reg;
        bump_next     = bump_reg;
        prev_next     = prev_reg;
        cur_next      = cur_reg;
        steps_next    = steps_reg;
        page_next     = page_reg;
        mem_ctl       = '0;
        rd_addr       = '0;
        wr_addr       = '0;
        link_wdata    = '0;
        len_wdata     = '0;
        fin           = 1'b0;
        fin_status    = ST_OK;
        fin_idx       = '0;
        fin_ok        = 1'b0;
        fin_reused    = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                if (kind_reg == KIND_ALLOC)
                begin
                    if (count_reg == '0)
                    begin
                        fin        = 1'b1;
                        fin_status = ST_IGNORED;
                        state_next = S_IDLE;
                    end
                    else if (head_reg < NIL)
                    begin
                        // first link read at the head
                        mem_ctl.rd_en = 1'b1;
                        rd_addr       = AW'(head_reg);
                        prev_next     = NIL;
                        cur_next      = head_reg;
                        steps_next    = '0;
                        state_next    = S_WALK;
                    end
                    else
                    begin
                        state_next = S_BUMP;
                    end
                end
                else
                begin
                    if (count_reg == '0 || addr_reg == '0)
                    begin
                        fin        = 1'b1;
                        fin_status = ST_IGNORED;
                        state_next = S_IDLE;
                    end
                    else if (addr_reg < heap_base)
                    begin
                        fin        = 1'b1;
                        fin_status = ST_RANGE;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        page_next  = PW'((addr_reg - heap_base) >> PAGE_SHIFT);
                        state_next = S_FREE_RANGE;
                    end
                end
            end

            S_WALK:
            begin
                if (rd_len == count_reg)
                begin
                    // exact fit: unlink cur
                    if (prev_reg == NIL)
                    begin
                        head_next = rd_link;
                    end
                    else
                    begin
                        mem_ctl.link_we = 1'b1;
                        wr_addr         = AW'(prev_reg);
                        link_wdata      = rd_link;
                    end
                    if (unlink_head >= NIL)
                    begin
                        tail_next = NIL;
                    end
                    else if (tail_reg == cur_reg)
                    begin
                        tail_next = prev_reg;
                    end
                    if (free_cnt_reg != '0)
                    begin
                        free_cnt_next = free_cnt_reg - 1'b1;
                    end
                    fin        = 1'b1;
                    fin_status = ST_OK;
                    fin_idx    = AW'(cur_reg);
                    fin_ok     = 1'b1;
                    fin_reused = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    prev_next  = cur_reg;
                    cur_next   = rd_link;
                    steps_next = steps_reg + 1'b1;
                    if (rd_link < NIL && steps_reg < STEP_MAX)
                    begin
                        mem_ctl.rd_en = 1'b1;
                        rd_addr       = AW'(rd_link);
                    end
                    else
                    begin
                        state_next = S_BUMP;
                    end
                end
            end

            S_BUMP:
            begin
                fin        = 1'b1;
                state_next = S_IDLE;
                if (bump_sum > SW'(PAGE_ENTRIES))
                begin
                    fin_status = ST_EXHAUSTED;
                end
                else
                begin
                    bump_next  = LW'(bump_sum);
                    fin_status = ST_OK;
                    fin_idx    = AW'(bump_reg);
                    fin_ok     = 1'b1;
                end
            end

            S_FREE_RANGE:
            begin
                if (page_ext >= RW'(PAGE_ENTRIES) || page_end > RW'(PAGE_ENTRIES))
                begin
                    fin        = 1'b1;
                    fin_status = ST_RANGE;
                    state_next = S_IDLE;
                end
                else
                begin
                    // append: hook old tail to the new run
                    if (list_empty)
                    begin
                        head_next = LW'(page_reg);
                    end
                    else
                    begin
                        mem_ctl.link_we = 1'b1;
                        wr_addr         = AW'(tail_reg);
                        link_wdata      = LW'(page_reg);
                    end
                    state_next = S_FREE_PAGE;
                end
            end

            S_FREE_PAGE:
            begin
                // after the tail hook so a repeated free ends the list here
                mem_ctl.link_we = 1'b1;
                mem_ctl.len_we  = 1'b1;
                wr_addr         = AW'(page_reg);
                link_wdata      = NIL;
                len_wdata       = count_reg;
                tail_next       = LW'(page_reg);
                if (free_cnt_reg < NIL)
                begin
                    free_cnt_next = free_cnt_reg + 1'b1;
                end
                fin        = 1'b1;
                fin_status = ST_OK;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result beat
    always_comb
    begin
        done_next            = fin;
        rsp_next.status      = fin_status;
        rsp_next.run_address = fin_ok ? (heap_base + (ADDR_W'(fin_idx) << PAGE_SHIFT)) : '0;
        rsp_next.run_index   = fin_ok ? RUN_INDEX_W'(fin_idx) : '0;
        rsp_next.reused      = fin_reused;
        rsp_next.free_runs   = FREE_RUNS_W'(free_cnt_next);
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            head_reg     <= NIL;
            tail_reg     <= NIL;
            free_cnt_reg <= '0;
            bump_reg     <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            free_cnt_reg <= free_cnt_next;
            bump_reg     <= bump_next;
            done_reg     <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            kind_reg  <= req.kind;
            count_reg <= req.page_count;
            addr_reg  <= req.address;
        end
        prev_reg  <= prev_next;
        cur_reg   <= cur_next;
        steps_reg <= steps_next;
        page_reg  <= page_next;
        rsp_reg   <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

`default_nettype wire

// File: sv/page_run_free_list_allocator.sv
// Page run allocator top level: config register, sequencer and link tables.
// The list walk reads one link per cycle through the tables' read port.
// The result beat comes in the first cycle with busy low; a start is taken in that cycle.
// Reset empties the free list and clears counters and heap_base; tables are not cleared.
`default_nettype none
`include "page_run_free_list_allocator_defines.svh"

module page_run_free_list_allocator #(
    parameter int PAGE_ENTRIES = prfl_pkg::PAGE_ENTRIES_DEF,
    parameter int PAGE_SHIFT   = prfl_pkg::PAGE_SHIFT_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire prfl_pkg::req_t              req,
    output logic                             done,
    output prfl_pkg::rsp_t                   rsp,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [prfl_pkg::ADDR_W-1:0] cfg_data
);
    import prfl_pkg::*;

    localparam int AW = $clog2(PAGE_ENTRIES);
    localparam int LW = AW + 1;

    logic [ADDR_W-1:0]  heap_base_reg;
    mem_ctl_t           mem_ctl;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic [LW-1:0]      link_wdata;
    logic [COUNT_W-1:0] len_wdata;
    logic [LW-1:0]      rd_link;
    logic [COUNT_W-1:0] rd_len;

    // Config register, written only while no request is in flight
    assign cfg_ready = !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_base_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            heap_base_reg <= cfg_data;
        end
    end

    prfl_ctrl #(
        .PAGE_ENTRIES (PAGE_ENTRIES),
        .PAGE_SHIFT   (PAGE_SHIFT)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req        (req),
        .heap_base  (heap_base_reg),
        .done       (done),
        .rsp        (rsp),
        .mem_ctl    (mem_ctl),
        .rd_addr    (rd_addr),
        .wr_addr    (wr_addr),
        .link_wdata (link_wdata),
        .len_wdata  (len_wdata),
        .rd_link    (rd_link),
        .rd_len     (rd_len)
    );

    prfl_store #(
        .PAGE_ENTRIES (PAGE_ENTRIES)
    ) u_store (
        .clk        (clk),
        .mem_ctl    (mem_ctl),
        .rd_addr    (rd_addr),
        .wr_addr    (wr_addr),
        .link_wdata (link_wdata),
        .len_wdata  (len_wdata),
        .rd_link    (rd_link),
        .rd_len     (rd_len)
    );

    // Checks
    `PRFL_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy, "accepted item did not raise busy")
    `PRFL_ASSERT_NOW(a_done_idle, clk, rst_n, done, !busy, "result beat while still busy")
    `PRFL_ASSERT_NOW(a_fail_clean, clk, rst_n, done && rsp.status != ST_OK, rsp.run_address == '0 && rsp.run_index == '0 && !rsp.reused, "failed request carries a run")
    `PRFL_ASSERT_NOW(a_reuse_ok, clk, rst_n, done && rsp.reused, rsp.status == ST_OK, "reused run with bad status")

endmodule

`default_nettype wire

// File: tb/sv/page_run_free_list_allocator_test.sv
// Self-checking testbench for the page run allocator: free-list reuse, bump allocation, heap_base.
`default_nettype none

module page_run_free_list_allocator_test;

    import prfl_pkg::*;

    localparam int PAGES = PAGE_ENTRIES_DEF;
    localparam int SHIFT = PAGE_SHIFT_DEF;
    localparam int NIL   = PAGES;

    // Predicts allocator responses and holds the responses still owed by the block
    class run_alloc_scoreboard;
        logic [ADDR_W-1:0] heap_base;
        int                link_of[PAGES];
        int                len_of[PAGES];
        int                head;
        int                tail;
        int                free_cnt;
        int                bump;
        rsp_t              expected_rsp[$];
        // Runs handed out and not yet freed, by first page and length
        int                live_page[$];
        int                live_len[$];
        int                errors;
        int                results;
        int                reuses;
        int                bumps;
        int                status_seen[4];

        function new();
            heap_base = '0;
            head      = NIL;
            tail      = NIL;
            free_cnt  = 0;
            bump      = 0;
            errors    = 0;
            results   = 0;
            reuses    = 0;
            bumps     = 0;
            foreach (link_of[i]) link_of[i] = 0;
            foreach (len_of[i]) len_of[i] = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        task log_mismatch(input string msg);
            $display("MISMATCH @%0t: %s", $time, msg);
            errors++;
        endtask

        // Apply one accepted request to the allocator state and build its response
        function rsp_t predict_run(input req_t r);
            rsp_t              e;
            int                prev;
            int                cur;
            int                nxt;
            int                steps;
            int                idx;
            bit                ok;
            bit                found;
            int unsigned       page;
            logic [ADDR_W-1:0] offs;
            e     = '0;
            ok    = 1'b0;
            found = 1'b0;
            idx   = 0;
            if (r.kind == KIND_ALLOC) begin
                if (r.page_count == 0) begin
                    e.status = ST_IGNORED;
                end else begin
                    // exact-fit walk from the head, bounded by the table depth
                    prev  = NIL;
                    cur   = head;
                    steps = 0;
                    while (!found && cur < NIL && steps < PAGES) begin
                        if (len_of[cur] == int'(r.page_count)) begin
                            found = 1'b1;
                            nxt   = link_of[cur];
                            if (prev == NIL)
                                head = nxt;
                            else
                                link_of[prev] = nxt;
                            if (tail == cur)
                                tail = prev;
                            if (head >= NIL)
                                tail = NIL;
                            if (free_cnt > 0)
                                free_cnt--;
                        end else begin
                            prev = cur;
                            cur  = link_of[cur];
                            steps++;
                        end
                    end
                    if (found) begin
                        ok       = 1'b1;
                        idx      = cur;
                        e.reused = 1'b1;
                        e.status = ST_OK;
                        reuses++;
                    end else if (bump + int'(r.page_count) > PAGES) begin
                        e.status = ST_EXHAUSTED;
                    end else begin
                        ok       = 1'b1;
                        idx      = bump;
                        bump     = bump + int'(r.page_count);
                        e.status = ST_OK;
                        bumps++;
                    end
                    if (ok) begin
                        live_page.push_back(idx);
                        live_len.push_back(int'(r.page_count));
                    end
                end
            end else begin
                if (r.page_count == 0 || r.address == 0) begin
                    e.status = ST_IGNORED;
                end else if (r.address < heap_base) begin
                    e.status = ST_RANGE;
                end else begin
                    offs = r.address - heap_base;
                    page = offs >> SHIFT;
                    if (page >= PAGES || page + r.page_count > PAGES) begin
                        e.status = ST_RANGE;
                    end else begin
                        // append at the tail
                        if (head >= NIL || tail >= NIL)
                            head = int'(page);
                        else
                            link_of[tail] = int'(page);
                        len_of[page]  = int'(r.page_count);
                        link_of[page] = NIL;
                        tail          = int'(page);
                        if (free_cnt < PAGES)
                            free_cnt++;
                        e.status = ST_OK;
                    end
                end
            end
            if (ok) begin
                e.run_address = heap_base + (ADDR_W'(idx) << SHIFT);
                e.run_index   = RUN_INDEX_W'(idx);
            end
            e.free_runs = FREE_RUNS_W'(free_cnt);
            return e;
        endfunction

        function void note_request(input req_t r);
            expected_rsp.push_back(predict_run(r));
        endfunction

        task check_response(input rsp_t got);
            rsp_t e;
            results++;
            status_seen[got.status]++;
            if (expected_rsp.size() == 0) begin
                log_mismatch("response beat with no request outstanding");
            end else begin
                e = expected_rsp.pop_front();
                if (got.status !== e.status)
                    log_mismatch($sformatf("status %0d, expected %0d", got.status, e.status));
                if (got.run_address !== e.run_address)
                    log_mismatch($sformatf("run_address %h, expected %h",
                                           got.run_address, e.run_address));
                if (got.run_index !== e.run_index)
                    log_mismatch($sformatf("run_index %0d, expected %0d",
                                           got.run_index, e.run_index));
                if (got.reused !== e.reused)
                    log_mismatch($sformatf("reused %0b, expected %0b", got.reused, e.reused));
                if (got.free_runs !== e.free_runs)
                    log_mismatch($sformatf("free_runs %0d, expected %0d",
                                           got.free_runs, e.free_runs));
            end
        endtask

        task flag_leftovers();
            if (expected_rsp.size() != 0)
                log_mismatch($sformatf("%0d responses never arrived", expected_rsp.size()));
        endtask
    endclass

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    req_t              req;
    logic              done;
    rsp_t              rsp;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [ADDR_W-1:0] cfg_data;

    run_alloc_scoreboard sb;
    bit                  no_gaps;
    int                  n_sent;
    int                  n_cfg;

    page_run_free_list_allocator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #40_000_000;
        $display("Timeout: allocator stopped making progress");
        $display("CHECKS FAILED");
        $finish;
    end

    // Response monitor: every strobed beat is checked
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            sb.check_response(rsp);
    end

    function automatic req_t mk(input logic [KIND_W-1:0] kind, input int count,
                                input logic [ADDR_W-1:0] addr);
        req_t r;
        r.kind       = kind;
        r.page_count = COUNT_W'(count);
        r.address    = addr;
        return r;
    endfunction

    // Hand one request beat to the block; entered and left at a falling edge
    task automatic send_request(input req_t r);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        req   <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_request(r);
        n_sent++;
        @(negedge clk);
    endtask

    // Stop sending and let every outstanding response come back
    task automatic wait_for_results();
        start <= 1'b0;
        while (sb.expected_rsp.size() > 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_heap_base(input logic [ADDR_W-1:0] v);
        wait_for_results();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.heap_base = v;
        n_cfg++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed traffic: allocations of small sizes and frees of live runs
    function automatic req_t build_request();
        req_t              r;
        int                pick;
        int                k;
        int                sel;
        logic [ADDR_W-1:0] base;
        r    = '0;
        base = sb.heap_base;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            r.kind    = KIND_ALLOC;
            r.address = $urandom();
            sel       = $urandom_range(0, 99);
            if (sel < 80)
                r.page_count = COUNT_W'($urandom_range(1, 8));
            else if (sel < 90)
                r.page_count = COUNT_W'($urandom_range(9, 64));
            else if (sel < 96)
                r.page_count = COUNT_W'($urandom_range(0, 2047));
            else
                r.page_count = '0;
        end else if (pick < 75 && sb.live_page.size() > 0) begin
            k            = $urandom_range(0, sb.live_page.size() - 1);
            r.kind       = KIND_FREE;
            r.page_count = COUNT_W'(sb.live_len[k]);
            r.address    = base + (ADDR_W'(sb.live_page[k]) << SHIFT);
            if ($urandom_range(0, 3) == 0)
                r.address = r.address + ADDR_W'($urandom_range(0, 4095));
            // keep the run now and then so it gets freed twice
            if ($urandom_range(0, 9) != 0) begin
                sb.live_page.delete(k);
                sb.live_len.delete(k);
            end
        end else if (pick < 88) begin
            r.kind       = KIND_FREE;
            r.page_count = COUNT_W'($urandom_range(1, 8));
            r.address    = base + (ADDR_W'($urandom_range(0, PAGES - 1)) << SHIFT);
        end else begin
            // noise
            r.kind       = KIND_W'($urandom_range(0, 1));
            r.page_count = COUNT_W'($urandom_range(0, 2047));
            r.address    = ($urandom_range(0, 3) == 0) ? '0 : ADDR_W'($urandom());
        end
        return r;
    endfunction

    // Main sequence
    initial
    begin
        logic [ADDR_W-1:0] phase_base[5];
        logic [ADDR_W-1:0] b;
        sb        = new();
        no_gaps   = 1'b0;
        n_sent    = 0;
        n_cfg     = 0;
        rst_n     = 1'b0;
        start     = 1'b0;
        req       = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: ignored requests, exhaustion, range errors, reuse, double free
        b = 32'h1000_0000;
        set_heap_base(b);
        send_request(mk(KIND_ALLOC, 0, '0));
        send_request(mk(KIND_FREE, 0, b));
        send_request(mk(KIND_FREE, 5, '0));
        send_request(mk(KIND_ALLOC, 1, '0));
        send_request(mk(KIND_ALLOC, 1024, '0));
        send_request(mk(KIND_ALLOC, 2047, 32'hFFFF_FFFF));
        send_request(mk(KIND_FREE, 1, b));
        send_request(mk(KIND_ALLOC, 1, '0));
        send_request(mk(KIND_ALLOC, 3, '0));
        send_request(mk(KIND_FREE, 1, b - 1));
        send_request(mk(KIND_FREE, 1, b + (32'd1024 << SHIFT)));
        send_request(mk(KIND_FREE, 5, b + (32'd1020 << SHIFT)));
        send_request(mk(KIND_FREE, 4, b + (32'd1020 << SHIFT)));
        send_request(mk(KIND_FREE, 2, b + (32'd1 << SHIFT) + 32'hABC));
        send_request(mk(KIND_FREE, 2, b + (32'd1 << SHIFT)));
        send_request(mk(KIND_FREE, 7, b + (32'd600 << SHIFT)));
        send_request(mk(KIND_ALLOC, 7, '0));
        send_request(mk(KIND_ALLOC, 2, '0));
        send_request(mk(KIND_ALLOC, 4, '0));
        send_request(mk(KIND_FREE, 2047, 32'hFFFF_FFFF));
        send_request(mk(KIND_ALLOC, 2, '0));
        // base near the top: run addresses wrap
        set_heap_base(32'hFFFF_F000);
        send_request(mk(KIND_ALLOC, 1, '0));
        send_request(mk(KIND_FREE, 1, 32'h0000_1000));
        send_request(mk(KIND_FREE, 1, 32'hFFFF_FFFF));

        // Random phases, one heap_base setting each
        phase_base[0] = '0;
        phase_base[1] = 32'hFFFF_FFFF;
        phase_base[2] = ADDR_W'($urandom()) & 32'hFFFF_F000;
        phase_base[3] = ADDR_W'($urandom());
        phase_base[4] = 32'h8000_0000;
        foreach (phase_base[p]) begin
            set_heap_base(phase_base[p]);
            for (int i = 0; i < 100; i++) begin
                if (i % 25 == 0)
                    no_gaps = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 99) == 0)
                    wait_for_results();
                send_request(build_request());
            end
        end

        // Drain, then allow one worst-case walk for any stray beat
        wait_for_results();
        repeat (PAGES + 8) @(posedge clk);
        sb.flag_leftovers();
        $display("Ran %0d requests over %0d heap_base settings: %0d reuses, %0d bump allocations.",
                 n_sent, n_cfg, sb.reuses, sb.bumps);
        $display("Responses %0d: ok %0d, ignored %0d, exhausted %0d, out of range %0d.",
                 sb.results, sb.status_seen[ST_OK], sb.status_seen[ST_IGNORED],
                 sb.status_seen[ST_EXHAUSTED], sb.status_seen[ST_RANGE]);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
